// ===== rtl/core/vnog_pkg.sv =====
// Shared types, constants and register codes of the value noise octave generator.
package vnog_pkg;

	// Defaults for the top level parameters.
	localparam int MAX_OCTAVES_DEF     = 8;
	localparam int INDEX_BITS_DEF      = 16;
	localparam int COS_TABLE_DEPTH_DEF = 256;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQUENCY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OFFSET  = 3'd4;

	// Register reset values.
	localparam logic [3:0]         OCTAVE_COUNT_RST   = 4'd3;
	localparam logic [31:0]        BASE_FREQUENCY_RST = 32'd16777;
	localparam logic signed [15:0] PERSISTENCE_RST    = 16'sd512;
	localparam logic signed [15:0] HEIGHT_SCALE_RST   = 16'sd100;
	localparam logic signed [15:0] HEIGHT_OFFSET_RST  = 16'sd100;

	// Field widths.
	localparam int X_W    = 16;
	localparam int PROD_W = 48;
	localparam int SUM_W  = 40;
	localparam int AMP_W  = 34;
	localparam int QUO_W  = 60;
	localparam int DIV_W  = 33;

	// Fixed-point constants.
	localparam longint unsigned ONE_Q30 = 64'd1073741824;
	localparam longint unsigned PI_Q30  = 64'd3373259426;

	// One point traveling down the octave chain.
	typedef struct packed {
		logic [X_W-1:0]           x;
		logic [PROD_W-1:0]        prod;
		logic signed [SUM_W-1:0]  r;
		logic signed [AMP_W-1:0]  amp;
	} oct_item_t;

	// One point traveling down the divider chain.
	typedef struct packed {
		logic [X_W-1:0]   x;
		logic             deg;
		logic             neg;
		logic [DIV_W-1:0] d;
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] nq;
	} div_item_t;

endpackage

// ===== rtl/core/vnog_octave_cell.sv =====
// One octave of the noise sum: hash, cosine blend, weighted add and amplitude step.
module vnog_octave_cell #(
	parameter int OCT             = 0,
	parameter int COS_TABLE_DEPTH = vnog_pkg::COS_TABLE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  vnog_pkg::oct_item_t in_item,
	input  logic [4:0]          n_eff,
	input  logic signed [15:0]  persistence,
	output logic                out_valid,
	output vnog_pkg::oct_item_t out_item
);
	import vnog_pkg::*;

	localparam int IDX_W = $clog2(COS_TABLE_DEPTH);
	localparam int FD_W  = 24 + IDX_W + 1;

	// Cosine weight table, built from the truncated series at elaboration.
	logic [30:0] rom [COS_TABLE_DEPTH];

	for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_rom
		localparam bit LOWER = (2 * k <= COS_TABLE_DEPTH);
		localparam longint unsigned KK = LOWER ? 64'(k) : 64'(COS_TABLE_DEPTH - k);
		localparam longint unsigned THETA = (KK * PI_Q30) / 64'(COS_TABLE_DEPTH);
		localparam longint unsigned X2 = (THETA * THETA) >> 30;
		localparam longint unsigned M1 = ((ONE_Q30 * X2) >> 30) / 2;
		localparam longint unsigned M2 = ((M1 * X2) >> 30) / 12;
		localparam longint unsigned M3 = ((M2 * X2) >> 30) / 30;
		localparam longint unsigned M4 = ((M3 * X2) >> 30) / 56;
		localparam longint unsigned M5 = ((M4 * X2) >> 30) / 90;
		localparam longint unsigned M6 = ((M5 * X2) >> 30) / 132;
		localparam longint unsigned M7 = ((M6 * X2) >> 30) / 182;
		localparam longint unsigned M8 = ((M7 * X2) >> 30) / 240;
		localparam longint unsigned M9 = ((M8 * X2) >> 30) / 306;
		localparam longint unsigned M10 = ((M9 * X2) >> 30) / 380;
		localparam longint CS = longint'(ONE_Q30) - longint'(M1) + longint'(M2)
			- longint'(M3) + longint'(M4) - longint'(M5) + longint'(M6)
			- longint'(M7) + longint'(M8) - longint'(M9) + longint'(M10);
		localparam longint CC = (CS < 0) ? 64'sd0 :
			((CS > longint'(ONE_Q30)) ? longint'(ONE_Q30) : CS);
		localparam longint HW = (longint'(ONE_Q30) - CC) >>> 1;
		localparam longint WV = LOWER ? HW : longint'(ONE_Q30) - HW;
		assign rom[k] = 31'(WV);
	end

	// Stage 1 inputs: lattice point, its neighbor and the table index.
	logic [63:0]      pos;
	logic [31:0]      ip;
	logic [31:0]      ip1;
	logic [FD_W-1:0]  fd;
	logic [IDX_W-1:0] idx;

	assign pos = 64'(in_item.prod) << OCT;
	assign ip  = pos[55:24];
	assign ip1 = ip + 32'd1;
	assign fd  = FD_W'(pos[23:0]) * FD_W'(COS_TABLE_DEPTH);
	assign idx = fd[24 +: IDX_W];

	// Hash tail and blend helpers.
	logic [31:0]        ha;
	logic [31:0]        hb;
	logic signed [31:0] wa;
	logic signed [31:0] wb;
	logic signed [63:0] bsum;
	logic signed [35:0] term;
	logic signed [41:0] pshift;
	logic signed [AMP_W-1:0] amp_next;
	logic               active;
	oct_item_t          acc_item;

	// Pipeline registers.
	logic        valid_s1, valid_s2, valid_s3, valid_s4;
	logic        valid_s5, valid_s6, valid_s7, valid_s8;
	oct_item_t   item_s1, item_s2, item_s3, item_s4, item_s5, item_s6, item_s7;
	oct_item_t   item_s8;
	logic [31:0] ta_s1, tb_s1, ta_s2, tb_s2, ta_s3, tb_s3;
	logic [30:0] w_s1, w_s2, w_s3, w_s4;
	logic [31:0] sqa_s2, sqb_s2;
	logic [31:0] va_s3, vb_s3;
	logic signed [31:0] na_s4, nb_s4;
	logic signed [63:0] pa_s5, pb_s5;
	logic signed [31:0] bl_s6;
	logic signed [65:0] tp_s7;
	logic signed [49:0] pp_s7;

	assign ha = ta_s3 * va_s3 + 32'd1376312589;
	assign hb = tb_s3 * vb_s3 + 32'd1376312589;
	assign wa = $signed({1'b0, 31'(ONE_Q30) - w_s4});
	assign wb = $signed({1'b0, w_s4});
	assign bsum = pa_s5 + pb_s5;
	assign term = 36'(tp_s7 >>> 30);
	assign pshift = 42'(pp_s7 >>> 8);
	assign active = (5'(OCT) < n_eff);

	// Amplitude saturates at plus or minus two to the 32nd.
	always_comb begin
		if (pshift > 42'sh100000000) begin
			amp_next = 34'sh100000000;
		end else if (pshift < -42'sh100000000) begin
			amp_next = -34'sh100000000;
		end else begin
			amp_next = AMP_W'(pshift);
		end
	end

	// Accumulate when this octave is in use.
	always_comb begin
		acc_item = item_s7;
		if (active) begin
			acc_item.r   = item_s7.r + SUM_W'(term);
			acc_item.amp = amp_next;
		end
	end

	// Valid bits of the cell stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	// Payload of the cell stages.
	always_ff @(posedge clk) begin
		if (en) begin
			// Hash prefix and weight lookup.
			item_s1 <= in_item;
			ta_s1   <= (ip << 13) ^ ip;
			tb_s1   <= (ip1 << 13) ^ ip1;
			w_s1    <= rom[idx];
			// Square of the hash word.
			item_s2 <= item_s1;
			ta_s2   <= ta_s1;
			tb_s2   <= tb_s1;
			w_s2    <= w_s1;
			sqa_s2  <= ta_s1 * ta_s1;
			sqb_s2  <= tb_s1 * tb_s1;
			// Polynomial of the hash word.
			item_s3 <= item_s2;
			ta_s3   <= ta_s2;
			tb_s3   <= tb_s2;
			w_s3    <= w_s2;
			va_s3   <= sqa_s2 * 32'd15731 + 32'd789221;
			vb_s3   <= sqb_s2 * 32'd15731 + 32'd789221;
			// Noise values in Q2.30.
			item_s4 <= item_s3;
			w_s4    <= w_s3;
			na_s4   <= 32'sh40000000 - $signed({1'b0, ha[30:0]});
			nb_s4   <= 32'sh40000000 - $signed({1'b0, hb[30:0]});
			// Weighted corners.
			item_s5 <= item_s4;
			pa_s5   <= wa * na_s4;
			pb_s5   <= wb * nb_s4;
			// Blend.
			item_s6 <= item_s5;
			bl_s6   <= 32'(bsum >>> 30);
			// Term and next amplitude products.
			item_s7 <= item_s6;
			tp_s7   <= bl_s6 * item_s6.amp;
			pp_s7   <= item_s6.amp * persistence;
			// Sum and amplitude after this octave.
			item_s8 <= acc_item;
		end
	end

	assign out_valid = valid_s8;
	assign out_item  = item_s8;

endmodule

// ===== rtl/core/vnog_div_cell.sv =====
// One step of the restoring divider: one quotient bit per cell.
module vnog_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  vnog_pkg::div_item_t in_item,
	output logic                out_valid,
	output vnog_pkg::div_item_t out_item
);
	import vnog_pkg::*;

	logic [DIV_W:0]   trial;
	logic             ge;
	logic             valid_q;
	div_item_t        item_q;
	div_item_t        step_item;

	// Bring down the next numerator bit and try the subtraction.
	assign trial = {in_item.rem, in_item.nq[QUO_W-1]};
	assign ge    = (trial >= {1'b0, in_item.d});

	// Partial remainder and shifted quotient after this step.
	always_comb begin
		step_item     = in_item;
		step_item.rem = ge ? DIV_W'(trial - {1'b0, in_item.d}) : DIV_W'(trial);
		step_item.nq  = {in_item.nq[QUO_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= step_item;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

// ===== rtl/core/value_noise_octave_generator.sv =====
// Path: input, octave cells, normalization, divider chain, clamp, scale, output.
// Throughput: one point per cycle whenever the output register is empty or taken.
// Each octave cell and divider step is registered, and all stages advance together.
// The divider is a chain of 60 one-bit cells.
// Reset clears all valid bits and loads the register reset values.
module value_noise_octave_generator #(
	parameter int MAX_OCTAVES     = vnog_pkg::MAX_OCTAVES_DEF,
	parameter int INDEX_BITS      = vnog_pkg::INDEX_BITS_DEF,
	parameter int COS_TABLE_DEPTH = vnog_pkg::COS_TABLE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [15:0]                       s_tdata,   // point_index
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [47:0]                       m_tdata,   // point_echo, height
	output logic                              m_tuser,   // degenerate
	input  logic                              cfg_we,
	input  logic [vnog_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [vnog_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import vnog_pkg::*;

	localparam int KEEP = (INDEX_BITS < X_W) ? INDEX_BITS : X_W;
	localparam logic [X_W-1:0] X_MASK = X_W'((17'(1) << KEEP) - 17'(1));

	// Configuration registers.
	logic [3:0]         octave_count_q;
	logic [31:0]        base_frequency_q;
	logic signed [15:0] persistence_q;
	logic signed [15:0] height_scale_q;
	logic signed [15:0] height_offset_q;
	logic [4:0]         n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q   <= OCTAVE_COUNT_RST;
			base_frequency_q <= BASE_FREQUENCY_RST;
			persistence_q    <= PERSISTENCE_RST;
			height_scale_q   <= HEIGHT_SCALE_RST;
			height_offset_q  <= HEIGHT_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OCTAVE_COUNT:   octave_count_q   <= cfg_data[3:0];
				REG_BASE_FREQUENCY: base_frequency_q <= cfg_data;
				REG_PERSISTENCE:    persistence_q    <= cfg_data[15:0];
				REG_HEIGHT_SCALE:   height_scale_q   <= cfg_data[15:0];
				REG_HEIGHT_OFFSET:  height_offset_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Octave counts above the cell count act as the cell count.
	assign n_eff = (5'(octave_count_q) > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES)
		: 5'(octave_count_q);

	// Global advance: a stage moves whenever the output register can take a transfer.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Input stage: mask the index and scale it by the base frequency.
	logic             valid_i1;
	oct_item_t        item_i1;
	logic [X_W-1:0]   x_in;

	assign x_in = s_tdata & X_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_i1 <= 1'b0;
		end else if (en) begin
			valid_i1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_i1.x    <= x_in;
			item_i1.prod <= PROD_W'(x_in) * PROD_W'(base_frequency_q);
			item_i1.r    <= '0;
			item_i1.amp  <= 34'sd65536;
		end
	end

	// Chain of octave cells.
	logic      oct_valid [MAX_OCTAVES+1];
	oct_item_t oct_item  [MAX_OCTAVES+1];

	assign oct_valid[0] = valid_i1;
	assign oct_item[0]  = item_i1;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		vnog_octave_cell #(
			.OCT             (i),
			.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (en),
			.in_valid    (oct_valid[i]),
			.in_item     (oct_item[i]),
			.n_eff       (n_eff),
			.persistence (persistence_q),
			.out_valid   (oct_valid[i+1]),
			.out_item    (oct_item[i+1])
		);
	end

	// Normalization numerator and divisor.
	oct_item_t          last_item;
	logic               valid_n1;
	logic [X_W-1:0]     x_n1;
	logic signed [57:0] num_n1;
	logic signed [34:0] div_n1;
	logic signed [17:0] pk;

	assign last_item = oct_item[MAX_OCTAVES];
	assign pk = 18'sd256 - 18'(persistence_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_n1 <= 1'b0;
		end else if (en) begin
			valid_n1 <= oct_valid[MAX_OCTAVES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_n1   <= last_item.x;
			num_n1 <= last_item.r * pk;
			div_n1 <= 35'sd65536 - 35'(last_item.amp);
		end
	end

	// Magnitudes and quotient sign for the divider.
	logic signed [63:0] numer;
	logic [63:0]        numer_mag;
	logic [34:0]        div_mag;
	logic               valid_n2;
	div_item_t          item_n2;

	assign numer     = 64'(num_n1) <<< 8;
	assign numer_mag = numer[63] ? 64'(-numer) : 64'(numer);
	assign div_mag   = div_n1[34] ? 35'(-div_n1) : 35'(div_n1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_n2 <= 1'b0;
		end else if (en) begin
			valid_n2 <= valid_n1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_n2.x   <= x_n1;
			item_n2.deg <= (div_n1 == 35'sd0);
			item_n2.neg <= numer[63] ^ div_n1[34];
			item_n2.d   <= div_mag[DIV_W-1:0];
			item_n2.rem <= '0;
			item_n2.nq  <= numer_mag[QUO_W-1:0];
		end
	end

	// Chain of divider cells.
	logic      dv_valid [QUO_W+1];
	div_item_t dv_item  [QUO_W+1];

	assign dv_valid[0] = valid_n2;
	assign dv_item[0]  = item_n2;

	for (genvar j = 0; j < QUO_W; j++) begin : g_div
		vnog_div_cell u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_valid[j]),
			.in_item   (dv_item[j]),
			.out_valid (dv_valid[j+1]),
			.out_item  (dv_item[j+1])
		);
	end

	// Clamp the quotient to two to the 40th and apply its sign.
	div_item_t          qd;
	logic [40:0]        qmag;
	logic               valid_n3;
	logic [X_W-1:0]     x_n3;
	logic               deg_n3;
	logic signed [41:0] nq_n3;

	assign qd   = dv_item[QUO_W];
	assign qmag = (qd.nq > 60'h100_0000_0000) ? 41'h100_0000_0000 : qd.nq[40:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_n3 <= 1'b0;
		end else if (en) begin
			valid_n3 <= dv_valid[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_n3   <= qd.x;
			deg_n3 <= qd.deg;
			nq_n3  <= qd.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
		end
	end

	// Height scale product.
	logic               valid_n4;
	logic [X_W-1:0]     x_n4;
	logic               deg_n4;
	logic signed [57:0] hp_n4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_n4 <= 1'b0;
		end else if (en) begin
			valid_n4 <= valid_n3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_n4   <= x_n3;
			deg_n4 <= deg_n3;
			hp_n4  <= nq_n3 * height_scale_q;
		end
	end

	// Offset, saturation and the output register.
	logic signed [50:0] hsum;
	logic signed [31:0] hsat;
	logic [X_W-1:0]     echo_q;
	logic signed [31:0] height_q;
	logic               deg_q;
	logic               out_valid_q;

	assign hsum = 51'(hp_n4 >>> 8) + (51'(height_offset_q) <<< 8);

	always_comb begin
		if (hsum > 51'sh7fffffff) begin
			hsat = 32'sh7fffffff;
		end else if (hsum < -51'sh80000000) begin
			hsat = 32'sh80000000;
		end else begin
			hsat = 32'(hsum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= valid_n4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			echo_q   <= x_n4;
			deg_q    <= deg_n4;
			height_q <= deg_n4 ? 32'sd0 : hsat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {height_q, echo_q};
	assign m_tuser  = deg_q;

endmodule
